// ===== design/knn_pkg.sv =====
// Shared types, codes and constants for the k-nearest-neighbor classifier.
// Depends on nothing; every other design file imports it.
package knn_pkg;

    localparam int FEATURE_WIDTH = 16;
    localparam int DEF_MAX_REFERENCES = 256;
    localparam int DEF_MAX_FEATURES = 16;
    localparam int DEF_MAX_CLASSES = 16;

    localparam int REQ_W = 2;
    localparam int REF_INDEX_W = 8;
    localparam int FEATURE_INDEX_W = 4;
    localparam int LABEL_W = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int K_W = 9;
    localparam int N_W = 9;
    localparam int P_W = 5;
    localparam int C_W = 5;

    localparam logic [REQ_W-1:0] REQ_REF_FEATURE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REF_LABEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_NEIGHBOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLASS = 2'd3;

    localparam logic [K_W-1:0] K_RESET = 9'd1;
    localparam logic [N_W-1:0] N_RESET = 9'd0;
    localparam logic [P_W-1:0] P_RESET = 5'd1;
    localparam logic [C_W-1:0] C_RESET = 5'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIST,
        ST_SEARCH,
        ST_VOTE_LT,
        ST_VOTE_EQ,
        ST_ARGMAX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } dist_ctl_t;

endpackage

// ===== design/knn_majority_classifier.sv =====
// k-nearest-neighbor majority classifier. Loads take one request per cycle while idle. A query
// request with last_item stalls the input for a tally clear pass, a distance pass that
// reads each reference's features and writes one distance per reference, a bitwise threshold
// search with one distance-memory pass per distance bit (DIST_W = 36 by default), two voting
// passes and a tally scan, each limited to one memory read per cycle. A result waits in an
// output register; loads are taken meanwhile. Error queries skip every pass and go straight
// to the done state.
module knn_majority_classifier
    import knn_pkg::*;
#(
    parameter int MAX_REFERENCES = DEF_MAX_REFERENCES,
    parameter int MAX_FEATURES = DEF_MAX_FEATURES,
    parameter int MAX_CLASSES = DEF_MAX_CLASSES
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [REQ_W-1:0]           req_type,
    input  logic [REF_INDEX_W-1:0]     ref_index,
    input  logic [FEATURE_INDEX_W-1:0] feature_index,
    input  logic [FEATURE_WIDTH-1:0]   feature_value,
    input  logic [LABEL_W-1:0]         class_label,
    input  logic                       last_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [LABEL_W-1:0]         predicted_class,
    output logic                       error_flag
);

    localparam int RI_W = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
    localparam int FI_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int RA_W = (MAX_REFERENCES * MAX_FEATURES > 1)
                          ? $clog2(MAX_REFERENCES * MAX_FEATURES) : 1;
    localparam int CNT_W = $clog2(MAX_REFERENCES + 1);
    localparam int PC_W = $clog2(MAX_FEATURES + 1);
    localparam int CI_W = $clog2(MAX_CLASSES);
    localparam int NC_W = $clog2(MAX_CLASSES + 1);
    localparam int DIST_W = 2 * FEATURE_WIDTH + $clog2(MAX_FEATURES);
    localparam int BI_W = $clog2(DIST_W);

    logic [K_W-1:0] k_reg;
    logic [N_W-1:0] n_reg;
    logic [P_W-1:0] p_reg;
    logic [C_W-1:0] c_reg;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] k_eff;
    logic [PC_W-1:0]  p_eff;
    logic [NC_W-1:0]  nc_eff;
    logic             cfg_err;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              issue_done_reg, issue_done_next;
    logic [NC_W-1:0]   cscan_reg, cscan_next;
    logic [FI_W-1:0]   f_reg, f_next;
    logic [RA_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [RI_W-1:0]   dwr_ptr_reg, dwr_ptr_next;
    dist_ctl_t         dctl_reg, dctl_next;
    logic              b_valid_reg, b_valid_next;
    logic              b_last_reg, b_last_next;
    logic              b_first_reg, b_first_next;
    logic [CI_W-1:0]   b_cidx_reg, b_cidx_next;
    logic [DIST_W-1:0] thr_reg, thr_next;
    logic [BI_W-1:0]   bit_reg, bit_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  vote_cnt_reg, vote_cnt_next;
    logic              tc_valid_reg, tc_valid_next;
    logic [CI_W-1:0]   tra_reg, tra_next;
    logic              lw_valid_reg;
    logic [CI_W-1:0]   lw_addr_reg;
    logic [CNT_W-1:0]  lw_data_reg;
    logic [CI_W-1:0]   best_reg, best_next;
    logic [CNT_W-1:0]  bestv_reg, bestv_next;
    logic [LABEL_W-1:0] res_class_reg, res_class_next;
    logic              res_err_reg, res_err_next;
    logic              out_valid_reg, out_valid_next;
    logic [LABEL_W-1:0] out_class_reg, out_class_next;
    logic              out_err_reg, out_err_next;

    logic in_acc;
    logic start;
    logic ri_ok;
    logic fi_ok;
    logic ref_we;
    logic lab_we;
    logic qry_we;
    logic [RA_W-1:0] ref_waddr;
    logic [RA_W-1:0] ref_raddr;
    logic [FEATURE_WIDTH-1:0] ref_q;
    logic [FEATURE_WIDTH-1:0] qry_q;
    logic [LABEL_W-1:0] lab_q;
    logic dist_wr_valid;
    logic [DIST_W-1:0] dist_wr_data;

    logic [DIST_W-1:0] dist_mem [MAX_REFERENCES];
    logic [DIST_W-1:0] dist_q_reg;
    logic [CNT_W-1:0]  tally_mem [MAX_CLASSES];
    logic [CNT_W-1:0]  tally_q_reg;
    logic              tally_we;
    logic [CI_W-1:0]   tally_waddr;
    logic [CNT_W-1:0]  tally_wdata;
    logic [CI_W-1:0]   tally_raddr;
    logic [CNT_W-1:0]  tally_val;

    logic [DIST_W-1:0] trial;
    logic              hit;
    logic [CNT_W-1:0]  cnt_upd;
    logic              elig;
    logic              upd;
    logic [RI_W-1:0]   scan_idx;

    assign n_eff = (int'(n_reg) > MAX_REFERENCES) ? CNT_W'(MAX_REFERENCES) : CNT_W'(n_reg);
    assign k_eff = (int'(k_reg) > int'(n_eff)) ? n_eff : CNT_W'(k_reg);
    assign p_eff = (int'(p_reg) > MAX_FEATURES) ? PC_W'(MAX_FEATURES) : PC_W'(p_reg);
    assign nc_eff = (int'(c_reg) > MAX_CLASSES) ? NC_W'(MAX_CLASSES) : NC_W'(c_reg);
    assign cfg_err = (k_reg == '0) || (n_eff == '0) || (p_eff == '0) || (nc_eff == '0);

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign ri_ok = int'(ref_index) < MAX_REFERENCES;
    assign fi_ok = int'(feature_index) < MAX_FEATURES;
    assign ref_we = in_acc && (req_type == REQ_REF_FEATURE) && ri_ok && fi_ok;
    assign lab_we = in_acc && (req_type == REQ_REF_LABEL) && ri_ok;
    assign qry_we = in_acc && (req_type == REQ_QUERY) && fi_ok;
    assign start = in_acc && (req_type == REQ_QUERY) && last_item;
    assign ref_waddr = RA_W'(int'(ref_index) * MAX_FEATURES + int'(feature_index));
    assign ref_raddr = base_reg + RA_W'(f_reg);
    assign scan_idx = scan_reg[RI_W-1:0];

    knn_store #(
        .MAX_REFERENCES(MAX_REFERENCES),
        .MAX_FEATURES(MAX_FEATURES)
    ) u_store (
        .clk(clk),
        .ref_we(ref_we),
        .ref_waddr(ref_waddr),
        .lab_we(lab_we),
        .lab_waddr(RI_W'(ref_index)),
        .qry_we(qry_we),
        .qry_waddr(FI_W'(feature_index)),
        .wr_value(feature_value),
        .wr_label(class_label),
        .ref_raddr(ref_raddr),
        .qry_raddr(f_reg),
        .lab_raddr(scan_idx),
        .ref_q(ref_q),
        .qry_q(qry_q),
        .lab_q(lab_q)
    );

    knn_dist_pipe #(
        .MAX_FEATURES(MAX_FEATURES)
    ) u_dist (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(dctl_reg),
        .ref_q(ref_q),
        .qry_q(qry_q),
        .wr_valid(dist_wr_valid),
        .wr_data(dist_wr_data)
    );

    always_ff @(posedge clk)
    begin
        if (dist_wr_valid)
        begin
            dist_mem[dwr_ptr_reg] <= dist_wr_data;
        end
        dist_q_reg <= dist_mem[scan_idx];
    end

    always_ff @(posedge clk)
    begin
        if (tally_we)
        begin
            tally_mem[tally_waddr] <= tally_wdata;
        end
        tally_q_reg <= tally_mem[tally_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
            n_reg <= N_RESET;
            p_reg <= P_RESET;
            c_reg <= C_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NEIGHBOR:  k_reg <= K_W'(cfg_data);
                CFG_REFERENCE: n_reg <= N_W'(cfg_data);
                CFG_FEATURE:   p_reg <= P_W'(cfg_data);
                CFG_CLASS:     c_reg <= C_W'(cfg_data);
                default:       k_reg <= k_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        scan_next = scan_reg;
        issue_done_next = issue_done_reg;
        cscan_next = cscan_reg;
        f_next = f_reg;
        base_next = base_reg;
        r_next = r_reg;
        dwr_ptr_next = dwr_ptr_reg;
        dctl_next = '0;
        b_valid_next = 1'b0;
        b_last_next = 1'b0;
        b_first_next = 1'b0;
        b_cidx_next = b_cidx_reg;
        thr_next = thr_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        vote_cnt_next = vote_cnt_reg;
        tc_valid_next = 1'b0;
        best_next = best_reg;
        bestv_next = bestv_reg;
        res_class_next = res_class_reg;
        res_err_next = res_err_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_class_next = out_class_reg;
        out_err_next = out_err_reg;

        tally_val = (lw_valid_reg && (lw_addr_reg == tra_reg)) ? lw_data_reg : tally_q_reg;
        tally_we = tc_valid_reg;
        tally_waddr = tra_reg;
        tally_wdata = tally_val + CNT_W'(1);
        tally_raddr = cscan_reg[CI_W-1:0];

        trial = thr_reg | ~({DIST_W{1'b1}} << bit_reg);
        hit = dist_q_reg <= trial;
        cnt_upd = cnt_reg + CNT_W'(hit);
        elig = 1'b0;
        upd = b_first_reg || (tally_val > bestv_reg);

        if (((state_reg == ST_SEARCH) || (state_reg == ST_VOTE_LT)
            || (state_reg == ST_VOTE_EQ)) && !issue_done_reg)
        begin
            b_valid_next = 1'b1;
            b_last_next = (int'(scan_reg) == int'(n_eff) - 1);
            scan_next = scan_reg + CNT_W'(1);
            if (int'(scan_reg) == int'(n_eff) - 1)
            begin
                issue_done_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cfg_err)
                    begin
                        res_class_next = '0;
                        res_err_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cscan_next = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                tally_we = 1'b1;
                tally_waddr = cscan_reg[CI_W-1:0];
                tally_wdata = '0;
                cscan_next = cscan_reg + NC_W'(1);
                if (int'(cscan_reg) == int'(nc_eff) - 1)
                begin
                    f_next = '0;
                    base_next = '0;
                    r_next = '0;
                    issue_done_next = 1'b0;
                    dwr_ptr_next = '0;
                    state_next = ST_DIST;
                end
            end
            ST_DIST:
            begin
                if (!issue_done_reg)
                begin
                    dctl_next.valid = 1'b1;
                    dctl_next.first = (f_reg == '0);
                    dctl_next.last = (int'(f_reg) == int'(p_eff) - 1);
                    if (int'(f_reg) == int'(p_eff) - 1)
                    begin
                        f_next = '0;
                        base_next = base_reg + RA_W'(MAX_FEATURES);
                        r_next = r_reg + CNT_W'(1);
                        if (int'(r_reg) == int'(n_eff) - 1)
                        begin
                            issue_done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        f_next = f_reg + FI_W'(1);
                    end
                end
                if (dist_wr_valid)
                begin
                    dwr_ptr_next = dwr_ptr_reg + RI_W'(1);
                    if (int'(dwr_ptr_reg) == int'(n_eff) - 1)
                    begin
                        thr_next = '0;
                        bit_next = BI_W'(DIST_W - 1);
                        scan_next = '0;
                        issue_done_next = 1'b0;
                        cnt_next = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (b_valid_reg)
                begin
                    cnt_next = cnt_upd;
                    if (b_last_reg)
                    begin
                        if (cnt_upd < k_eff)
                        begin
                            thr_next = thr_reg | (DIST_W'(1) << bit_reg);
                        end
                        scan_next = '0;
                        issue_done_next = 1'b0;
                        cnt_next = '0;
                        if (bit_reg == '0)
                        begin
                            vote_cnt_next = '0;
                            state_next = ST_VOTE_LT;
                        end
                        else
                        begin
                            bit_next = bit_reg - BI_W'(1);
                        end
                    end
                end
            end
            ST_VOTE_LT, ST_VOTE_EQ:
            begin
                tally_raddr = CI_W'(lab_q);
                if (state_reg == ST_VOTE_LT)
                begin
                    elig = dist_q_reg < thr_reg;
                end
                else
                begin
                    elig = (dist_q_reg == thr_reg) && (vote_cnt_reg < k_eff);
                end
                if (b_valid_reg)
                begin
                    if (elig)
                    begin
                        vote_cnt_next = vote_cnt_reg + CNT_W'(1);
                        tc_valid_next = int'(lab_q) < int'(nc_eff);
                    end
                    if (b_last_reg)
                    begin
                        scan_next = '0;
                        issue_done_next = 1'b0;
                        cscan_next = '0;
                        state_next = (state_reg == ST_VOTE_LT) ? ST_VOTE_EQ : ST_ARGMAX;
                    end
                end
            end
            ST_ARGMAX:
            begin
                if (!issue_done_reg)
                begin
                    b_valid_next = 1'b1;
                    b_last_next = (int'(cscan_reg) == int'(nc_eff) - 1);
                    b_first_next = (cscan_reg == '0);
                    b_cidx_next = cscan_reg[CI_W-1:0];
                    cscan_next = cscan_reg + NC_W'(1);
                    if (int'(cscan_reg) == int'(nc_eff) - 1)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (b_valid_reg)
                begin
                    if (upd)
                    begin
                        best_next = b_cidx_reg;
                        bestv_next = tally_val;
                    end
                    if (b_last_reg)
                    begin
                        res_class_next = LABEL_W'(upd ? b_cidx_reg : best_reg);
                        res_err_next = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_class_next = res_class_reg;
                    out_err_next = res_err_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        tra_next = tally_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            issue_done_reg <= 1'b0;
            dctl_reg <= '0;
            b_valid_reg <= 1'b0;
            b_last_reg <= 1'b0;
            b_first_reg <= 1'b0;
            tc_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_reg <= '0;
            cscan_reg <= '0;
            vote_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            issue_done_reg <= issue_done_next;
            dctl_reg <= dctl_next;
            b_valid_reg <= b_valid_next;
            b_last_reg <= b_last_next;
            b_first_reg <= b_first_next;
            tc_valid_reg <= tc_valid_next;
            lw_valid_reg <= tally_we;
            out_valid_reg <= out_valid_next;
            scan_reg <= scan_next;
            cscan_reg <= cscan_next;
            vote_cnt_reg <= vote_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        base_reg <= base_next;
        r_reg <= r_next;
        dwr_ptr_reg <= dwr_ptr_next;
        b_cidx_reg <= b_cidx_next;
        thr_reg <= thr_next;
        bit_reg <= bit_next;
        cnt_reg <= cnt_next;
        tra_reg <= tra_next;
        lw_addr_reg <= tally_waddr;
        lw_data_reg <= tally_wdata;
        best_reg <= best_next;
        bestv_reg <= bestv_next;
        res_class_reg <= res_class_next;
        res_err_reg <= res_err_next;
        out_class_reg <= out_class_next;
        out_err_reg <= out_err_next;
    end

    assign out_valid = out_valid_reg;
    assign predicted_class = out_class_reg;
    assign error_flag = out_err_reg;

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");

    a_votes_within_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VOTE_EQ) |-> (vote_cnt_reg <= k_eff))
        else $error("more votes than neighbors");

    a_dist_write_in_dist: assert property (@(posedge clk) disable iff (!rst_n)
        dist_wr_valid |-> (state_reg == ST_DIST))
        else $error("distance write outside the distance pass");

    a_error_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_class_reg == '0))
        else $error("error result with nonzero class");

endmodule

// ===== design/knn_store.sv =====
// Reference feature, reference label and query feature memories.
// Synchronous write, one registered read port each; uses knn_pkg.
module knn_store
    import knn_pkg::*;
#(
    parameter int MAX_REFERENCES = DEF_MAX_REFERENCES,
    parameter int MAX_FEATURES = DEF_MAX_FEATURES,
    localparam int RI_W = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1,
    localparam int FI_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
    localparam int RA_W = (MAX_REFERENCES * MAX_FEATURES > 1)
                          ? $clog2(MAX_REFERENCES * MAX_FEATURES) : 1
)
(
    input  logic                     clk,
    input  logic                     ref_we,
    input  logic [RA_W-1:0]          ref_waddr,
    input  logic                     lab_we,
    input  logic [RI_W-1:0]          lab_waddr,
    input  logic                     qry_we,
    input  logic [FI_W-1:0]          qry_waddr,
    input  logic [FEATURE_WIDTH-1:0] wr_value,
    input  logic [LABEL_W-1:0]       wr_label,
    input  logic [RA_W-1:0]          ref_raddr,
    input  logic [FI_W-1:0]          qry_raddr,
    input  logic [RI_W-1:0]          lab_raddr,
    output logic [FEATURE_WIDTH-1:0] ref_q,
    output logic [FEATURE_WIDTH-1:0] qry_q,
    output logic [LABEL_W-1:0]       lab_q
);

    logic [FEATURE_WIDTH-1:0] ref_mem [MAX_REFERENCES*MAX_FEATURES];
    logic [LABEL_W-1:0]       lab_mem [MAX_REFERENCES];
    logic [FEATURE_WIDTH-1:0] qry_mem [MAX_FEATURES];

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_waddr] <= wr_value;
        end
        ref_q <= ref_mem[ref_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            lab_mem[lab_waddr] <= wr_label;
        end
        lab_q <= lab_mem[lab_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (qry_we)
        begin
            qry_mem[qry_waddr] <= wr_value;
        end
        qry_q <= qry_mem[qry_raddr];
    end

endmodule

// ===== design/knn_dist_pipe.sv =====
// Squared-distance pipeline: difference, square, accumulate over features.
// Emits one distance per reference on its last feature; uses knn_pkg.
module knn_dist_pipe
    import knn_pkg::*;
#(
    parameter int MAX_FEATURES = DEF_MAX_FEATURES,
    localparam int DIST_W = 2 * FEATURE_WIDTH + $clog2(MAX_FEATURES)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dist_ctl_t                ctl,
    input  logic [FEATURE_WIDTH-1:0] ref_q,
    input  logic [FEATURE_WIDTH-1:0] qry_q,
    output logic                     wr_valid,
    output logic [DIST_W-1:0]        wr_data
);

    localparam int SQ_W = 2 * FEATURE_WIDTH;

    dist_ctl_t                s1_ctl_reg;
    dist_ctl_t                s2_ctl_reg;
    logic [FEATURE_WIDTH-1:0] s1_abs_reg;
    logic [SQ_W-1:0]          s2_sq_reg;
    logic [DIST_W-1:0]        acc_reg;
    logic [FEATURE_WIDTH:0]   diff;
    logic [FEATURE_WIDTH:0]   diff_abs;
    logic [DIST_W-1:0]        sum;

    always_comb
    begin
        diff = {qry_q[FEATURE_WIDTH-1], qry_q} - {ref_q[FEATURE_WIDTH-1], ref_q};
        diff_abs = diff[FEATURE_WIDTH] ? (~diff + 1'b1) : diff;
        sum = (s2_ctl_reg.first ? '0 : acc_reg) + DIST_W'(s2_sq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_abs_reg <= diff_abs[FEATURE_WIDTH-1:0];
        s2_sq_reg <= SQ_W'(s1_abs_reg) * SQ_W'(s1_abs_reg);
        if (s2_ctl_reg.valid)
        begin
            acc_reg <= sum;
        end
    end

    assign wr_valid = s2_ctl_reg.valid && s2_ctl_reg.last;
    assign wr_data = sum;

endmodule
